[sv/efws_pkg.sv]
// Shared types and constants for the earliest-free worker scheduler.
`timescale 1ns / 1ps
package efws_pkg;

  localparam int TIME_W    = 48;
  localparam int DUR_W     = 32;
  localparam int OUT_IDX_W = 4;
  localparam int CFG_W     = 5;

  localparam logic [CFG_W-1:0] ACTIVE_RST = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic rd_done;
  } ctl_sts_t;

endpackage

[sv/earliest_free_worker_scheduler.sv]
// Top level of the earliest-free worker scheduler.
//
// Assigns each job request to the enabled worker with the smallest free time,
// lowest index on ties, and advances that worker's free time by the job's
// duration, saturating at 2^48-1.
//
// Input: a request is taken at a rising edge with start high and busy low.
// Output: each result is shown for one cycle with out_valid high; the receiver
// cannot stall it.
// Configuration: cfg_we writes cfg_wdata into the active-worker count (0 acts
// as 1, values above WORKERS act as WORKERS). Write only while busy is low.
//
// Timing: out_valid rises after the scan of the N enabled workers and the
// compare, update and result stages; busy drops in that same cycle, so the
// next request can be taken at the edge that ends the strobe. The free-time
// memory is read one worker per cycle during the scan. A new request is not
// taken until the result of the one before it is shown.
//
// Reset: all free times read as zero and the active-worker count is 16.
// A request with in_new_batch set clears all free times before it is scheduled.
`timescale 1ns / 1ps
module earliest_free_worker_scheduler
  import efws_pkg::*;
#(
  parameter int WORKERS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [DUR_W-1:0]     in_job_duration,
  input  logic                 in_new_batch,
  output logic                 out_valid,
  output logic [OUT_IDX_W-1:0] out_worker_index,
  output logic [TIME_W-1:0]    out_start_time,
  output logic                 out_time_saturated,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  efws_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  efws_dp #(
    .WORKERS (WORKERS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_job_duration    (in_job_duration),
    .in_new_batch       (in_new_batch),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_worker_index   (out_worker_index),
    .out_start_time     (out_start_time),
    .out_time_saturated (out_time_saturated)
  );

endmodule

[sv/efws_ctrl.sv]
// Controller state machine: accept a request, sequence the scan and the update.
`timescale 1ns / 1ps
module efws_ctrl
  import efws_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output ctl_cmd_t cmd,
  input  ctl_sts_t sts
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // last compare happens in the cycle the read counter reaches the end
        if (!sts.rd_done) begin
          cmd.rd = 1'b1;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/efws_dp.sv]
// Datapath: free-time memory, minimum search, saturating update and result register.
`timescale 1ns / 1ps
module efws_dp
  import efws_pkg::*;
#(
  parameter int WORKERS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [DUR_W-1:0]     in_job_duration,
  input  logic                 in_new_batch,
  input  ctl_cmd_t             cmd,
  output ctl_sts_t             sts,
  output logic                 out_valid,
  output logic [OUT_IDX_W-1:0] out_worker_index,
  output logic [TIME_W-1:0]    out_start_time,
  output logic                 out_time_saturated
);

  localparam int IDX_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int CNT_W = $clog2(WORKERS + 1);

  logic [TIME_W-1:0]  mem [WORKERS];
  logic [WORKERS-1:0] vld_r;

  logic [CFG_W-1:0]   active_r;
  logic [DUR_W-1:0]   dur_r;
  logic [CNT_W-1:0]   n_r;
  logic [CNT_W-1:0]   n_load;
  logic [CNT_W-1:0]   rd_addr_r;
  logic [TIME_W-1:0]  mem_q_r;
  logic               rd_vld_r;
  logic               cmp_vld_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic [TIME_W-1:0]  cmp_time;
  logic [IDX_W-1:0]   best_idx_r;
  logic [TIME_W-1:0]  best_time_r;
  logic [TIME_W:0]    sum;
  logic               sat;
  logic [TIME_W-1:0]  new_time;

  logic                 out_valid_r;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic [TIME_W-1:0]    out_start_r;
  logic                 out_sat_r;

  // clamp the worker count to 1 .. WORKERS
  always_comb begin
    if (active_r == '0) begin
      n_load = CNT_W'(1);
    end else if (32'(active_r) > WORKERS) begin
      n_load = CNT_W'(WORKERS);
    end else begin
      n_load = CNT_W'(active_r);
    end
  end

  assign sts.rd_done = (rd_addr_r == n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RST;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[best_idx_r] <= new_time;
    end
    if (cmd.rd) begin
      mem_q_r <= mem[rd_addr_r[IDX_W-1:0]];
    end
  end

  // an entry never written since reset or a new batch reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.load && in_new_batch) begin
      vld_r <= '0;
    end else if (cmd.commit) begin
      vld_r[best_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.rd;
      if (cmd.load) begin
        rd_addr_r <= '0;
      end else if (cmd.rd) begin
        rd_addr_r <= rd_addr_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dur_r <= in_job_duration;
      n_r   <= n_load;
    end
    if (cmd.rd) begin
      rd_vld_r  <= vld_r[rd_addr_r[IDX_W-1:0]];
      cmp_idx_r <= rd_addr_r[IDX_W-1:0];
    end
  end

  assign cmp_time = rd_vld_r ? mem_q_r : '0;

  // strict less-than keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (cmp_vld_r) begin
      if (cmp_idx_r == '0 || cmp_time < best_time_r) begin
        best_idx_r  <= cmp_idx_r;
        best_time_r <= cmp_time;
      end
    end
  end

  assign sum      = {1'b0, best_time_r} + (TIME_W + 1)'(dur_r);
  assign sat      = sum[TIME_W];
  assign new_time = sat ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_idx_r   <= OUT_IDX_W'(best_idx_r);
      out_start_r <= best_time_r;
      out_sat_r   <= sat;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_worker_index   = out_idx_r;
  assign out_start_time     = out_start_r;
  assign out_time_saturated = out_sat_r;

endmodule
